/* design/nps_pkg.sv */
package nps_pkg;

  // table sizes
  localparam int MAX_POINTS   = 1024;
  localparam int MAX_SEGMENTS = 1024;
  localparam int PT_AW        = $clog2(MAX_POINTS);
  localparam int SG_AW        = $clog2(MAX_SEGMENTS);

  // field widths
  localparam int CW      = 28;  // coordinate
  localparam int DW      = 29;  // coordinate difference, distance
  localparam int SLOT_W  = 10;
  localparam int ID_W    = 16;
  localparam int CNT_W   = 11;
  localparam int CFG_AW  = 1;
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 104;

  // arithmetic widths
  localparam int MUL_W   = 31;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int DEN_W   = 59;
  localparam int NUM_W   = 88;
  localparam int SQ_W    = 58;
  localparam int QW      = 30;
  localparam int LO_W    = 30;  // low slice of the dot product
  localparam int ITER_STEPS = 29;
  localparam int ITER_CW    = $clog2(ITER_STEPS + 1);

  localparam logic [DW-1:0] DIST_MAX = '1;

  typedef enum logic [1:0] {
    FN_PT    = 2'd0,
    FN_SEG   = 2'd1,
    FN_QUERY = 2'd2,
    FN_NOP   = 2'd3
  } func_t;

  localparam logic [CFG_AW-1:0] CFG_POINT_COUNT = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_SEG_COUNT   = 1'b1;

  typedef struct packed {
    logic start;
    logic is_sqrt;
  } iter_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_sts_t;

endpackage

/* design/nps_ram.sv */
module nps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/nps_iter.sv */
module nps_iter (
  input  logic                      clk,
  input  logic                      rst_n,
  input  nps_pkg::iter_ctl_t        ctl,
  input  logic [nps_pkg::NUM_W-1:0] num,
  input  logic [nps_pkg::DEN_W-1:0] den,
  output nps_pkg::iter_sts_t        sts,
  output logic [nps_pkg::QW-1:0]    res
);
  import nps_pkg::*;

  localparam int AW = DEN_W + 1;

  logic [AW-1:0]      acc_r;
  logic [SQ_W-1:0]    sh_r;
  logic [QW-1:0]      q_r;
  logic [DEN_W-1:0]   den_r;
  logic               sq_r;
  logic               busy_r;
  logic [ITER_CW-1:0] cnt_r;

  logic [AW:0]   shifted;
  logic [AW:0]   subtr;
  logic [AW+1:0] diff;
  logic          ge;
  logic          inc;
  logic          done;

  // one digit per step: a restoring divide bit or a square-root bit pair
  always_comb begin
    if (sq_r) begin
      shifted = {acc_r[AW-2:0], sh_r[SQ_W-1 -: 2]};
      subtr   = (AW+1)'({q_r, 2'b01});
    end else begin
      shifted = {acc_r, sh_r[SQ_W-1]};
      subtr   = (AW+1)'(den_r);
    end
    diff = {1'b0, shifted} - {1'b0, subtr};
    ge   = !diff[AW+1];
  end

  // round to nearest from the final remainder
  always_comb begin
    if (sq_r) begin
      inc = acc_r > AW'(q_r);
    end else begin
      inc = {acc_r, 1'b0} >= (AW+1)'(den_r);
    end
  end

  assign done     = busy_r && (cnt_r == '0);
  assign res      = q_r + QW'(inc);
  assign sts.busy = busy_r;
  assign sts.done = done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctl.start) begin
      busy_r <= 1'b1;
      cnt_r  <= ITER_CW'(ITER_STEPS);
      sq_r   <= ctl.is_sqrt;
      den_r  <= den;
      q_r    <= '0;
      if (ctl.is_sqrt) begin
        acc_r <= '0;
        sh_r  <= num[SQ_W-1:0];
      end else begin
        acc_r <= AW'(num[NUM_W-1:ITER_STEPS]);
        sh_r  <= {num[ITER_STEPS-1:0], (SQ_W-ITER_STEPS)'(0)};
      end
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      acc_r <= ge ? diff[AW-1:0] : shifted[AW-1:0];
      sh_r  <= sq_r ? (sh_r << 2) : (sh_r << 1);
      q_r   <= {q_r[QW-2:0], ge};
    end
  end

endmodule

/* design/nearest_point_on_segments.sv */
// Write beats (point or segment slot) are taken in ST_IDLE; the block stays ready after one.
// A query scans the segments in turn. Out-of-range endpoints skip a segment; a clamped
// projection needs one square root, any other two divides and a square root, so up to
// three uses per segment of the shared divide/sqrt unit; one item at a time.
// Reset (synchronous, rst_n low) clears the sequencer, output valid and both counts;
// point and segment tables are undefined until written.
module nearest_point_on_segments (
  input  logic                            clk,
  input  logic                            rst_n,
  // cfg
  input  logic                            cfg_we,
  input  logic [nps_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [nps_pkg::CNT_W-1:0]       cfg_wdata,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // slot, x_pos, y_pos, first_point, second_point, segment_tag, zero pad
  input  logic [nps_pkg::IN_TDATA_W-1:0]  in_tdata,
  // func
  input  logic [1:0]                      in_tuser,
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // distance, proj_x, proj_y, nearest_id, zero pad
  output logic [nps_pkg::OUT_TDATA_W-1:0] out_tdata,
  // found
  output logic                            out_tuser
);
  import nps_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SEG_RD, ST_SEG_CHK, ST_PA, ST_PB,
    ST_M_DXX, ST_M_DYY, ST_M_WX, ST_M_WY, ST_DOT, ST_CLAMP,
    ST_P_LO, ST_P_HI, ST_P_DIV, ST_P_WAIT,
    ST_ERR, ST_E_XX, ST_E_YY, ST_E_SUM, ST_SQ_WAIT, ST_FIN
  } state_t;

  state_t state_r;

  // input fields
  logic [SLOT_W-1:0] f_slot;
  logic [CW-1:0]     f_x, f_y;
  logic [SLOT_W-1:0] f_first, f_second;
  logic [ID_W-1:0]   f_tag;
  func_t             f_func;

  assign f_slot   = in_tdata[9:0];
  assign f_x      = in_tdata[37:10];
  assign f_y      = in_tdata[65:38];
  assign f_first  = in_tdata[75:66];
  assign f_second = in_tdata[85:76];
  assign f_tag    = in_tdata[101:86];
  assign f_func   = func_t'(in_tuser);

  logic in_acc;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // config registers
  logic [CNT_W-1:0] pt_count_r, seg_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_count_r  <= '0;
      seg_count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_POINT_COUNT: pt_count_r  <= cfg_wdata;
        CFG_SEG_COUNT:   seg_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // tables
  logic [2*CW-1:0]          pt_rdata;
  logic [PT_AW-1:0]         pt_raddr;
  logic [2*SLOT_W+ID_W-1:0] sg_rdata;
  logic [SG_AW:0]           seg_idx_r;
  logic [SLOT_W-1:0]        i1_r;
  logic [ID_W-1:0]          id_r;

  nps_ram #(.WIDTH(2*CW), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk   (clk),
    .we    (in_acc && f_func == FN_PT),
    .waddr (PT_AW'(f_slot)),
    .wdata ({f_y, f_x}),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  nps_ram #(.WIDTH(2*SLOT_W+ID_W), .DEPTH(MAX_SEGMENTS)) u_sg_ram (
    .clk   (clk),
    .we    (in_acc && f_func == FN_SEG),
    .waddr (SG_AW'(f_slot)),
    .wdata ({f_tag, f_second, f_first}),
    .raddr (seg_idx_r[SG_AW-1:0]),
    .rdata (sg_rdata)
  );

  logic [SLOT_W-1:0] sg_start, sg_end;
  logic [ID_W-1:0]   sg_id;
  assign sg_start = sg_rdata[SLOT_W-1:0];
  assign sg_end   = sg_rdata[2*SLOT_W-1:SLOT_W];
  assign sg_id    = sg_rdata[2*SLOT_W+ID_W-1:2*SLOT_W];

  assign pt_raddr = (state_r == ST_SEG_CHK) ? PT_AW'(sg_start) : PT_AW'(i1_r);

  // working registers
  logic [CW-1:0]     qx_r, qy_r, ax_r, ay_r, bx_r, by_r, px_r, py_r;
  logic [DW-1:0]     dx_r, dy_r, wx_r, wy_r, ex_r, ey_r;
  logic [DEN_W-1:0]  len2_r, dot_r;
  logic [DEN_W-1:0]  nlo_r;
  logic [SQ_W-1:0]   s_r;
  logic              axis_r;
  logic signed [PROD_W-1:0] p_r;

  // best so far
  logic              found_r;
  logic [DW-1:0]     best_r;
  logic [CW-1:0]     bx_best_r, by_best_r;
  logic [ID_W-1:0]   bid_r;

  // output register
  logic              out_tvalid_r;
  logic              out_found_r;
  logic [DW-1:0]     out_dist_r;
  logic [CW-1:0]     out_px_r, out_py_r;
  logic [ID_W-1:0]   out_id_r;

  function automatic logic [MUL_W-1:0] sx(input logic [DW-1:0] v);
    sx = {{(MUL_W-DW){v[DW-1]}}, v};
  endfunction

  function automatic logic [DW-1:0] ext(input logic [CW-1:0] v);
    ext = {v[CW-1], v};
  endfunction

  // magnitude of the current axis difference
  logic [DW-1:0] d_cur, mag;
  logic [CW-1:0] a_cur;
  assign d_cur = axis_r ? dy_r : dx_r;
  assign a_cur = axis_r ? ay_r : ax_r;
  assign mag   = d_cur[DW-1] ? DW'(-d_cur) : d_cur;

  // shared multiplier, operands by state
  logic [MUL_W-1:0] mul_a, mul_b;

  always_comb begin
    case (state_r)
      ST_M_DXX: begin mul_a = sx(dx_r); mul_b = sx(dx_r); end
      ST_M_DYY: begin mul_a = sx(dy_r); mul_b = sx(dy_r); end
      ST_M_WX:  begin mul_a = sx(wx_r); mul_b = sx(dx_r); end
      ST_M_WY:  begin mul_a = sx(wy_r); mul_b = sx(dy_r); end
      ST_P_LO:  begin mul_a = MUL_W'(mag); mul_b = MUL_W'(dot_r[LO_W-1:0]); end
      ST_P_HI:  begin mul_a = MUL_W'(mag); mul_b = MUL_W'(dot_r[DEN_W-1:LO_W]); end
      ST_E_XX:  begin mul_a = sx(ex_r); mul_b = sx(ex_r); end
      ST_E_YY:  begin mul_a = sx(ey_r); mul_b = sx(ey_r); end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    p_r <= $signed(mul_a) * $signed(mul_b);
  end

  // divide / square-root unit
  iter_ctl_t         it_ctl;
  iter_sts_t         it_sts;
  logic [NUM_W-1:0]  it_num;
  logic [QW-1:0]     it_res;

  always_comb begin
    it_ctl.start   = (state_r == ST_P_DIV) || (state_r == ST_E_SUM);
    it_ctl.is_sqrt = (state_r == ST_E_SUM);
    if (state_r == ST_E_SUM) begin
      it_num = NUM_W'(s_r + SQ_W'(p_r));
    end else begin
      it_num = (NUM_W'(p_r) << LO_W) + NUM_W'(nlo_r);
    end
  end

  nps_iter u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (it_ctl),
    .num   (it_num),
    .den   (len2_r),
    .sts   (it_sts),
    .res   (it_res)
  );

  // comb helpers
  logic          dot_nonpos, dot_ge;
  logic [DW-1:0] proj, dist_sat;
  logic          out_free;

  assign dot_nonpos = dot_r[DEN_W-1] || (dot_r == '0);
  assign dot_ge     = dot_r >= len2_r;
  assign proj       = d_cur[DW-1] ? (ext(a_cur) - DW'(it_res)) : (ext(a_cur) + DW'(it_res));
  assign dist_sat   = (it_res > QW'(DIST_MAX)) ? DIST_MAX : it_res[DW-1:0];
  assign out_free   = !out_tvalid_r || out_tready;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      axis_r       <= 1'b0;
      found_r      <= 1'b0;
      seg_idx_r    <= '0;
    end else begin
      // a beat leaving while a new one loads is handled in ST_FIN
      if (out_tvalid_r && out_tready && state_r != ST_FIN) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc && f_func == FN_QUERY) begin
            qx_r      <= f_x;
            qy_r      <= f_y;
            found_r   <= 1'b0;
            best_r    <= DIST_MAX;
            bx_best_r <= '0;
            by_best_r <= '0;
            bid_r     <= '0;
            seg_idx_r <= '0;
            state_r   <= ST_SEG_RD;
          end
        end
        ST_SEG_RD: begin
          if (seg_idx_r >= seg_count_r || seg_idx_r == (SG_AW+1)'(MAX_SEGMENTS)) begin
            state_r <= ST_FIN;
          end else begin
            state_r <= ST_SEG_CHK;
          end
        end
        ST_SEG_CHK: begin
          i1_r <= sg_end;
          id_r <= sg_id;
          if (CNT_W'(sg_start) >= pt_count_r || CNT_W'(sg_end) >= pt_count_r) begin
            seg_idx_r <= seg_idx_r + 1'b1;
            state_r   <= ST_SEG_RD;
          end else begin
            state_r <= ST_PA;
          end
        end
        ST_PA: begin
          ax_r    <= pt_rdata[CW-1:0];
          ay_r    <= pt_rdata[2*CW-1:CW];
          wx_r    <= ext(qx_r) - ext(pt_rdata[CW-1:0]);
          wy_r    <= ext(qy_r) - ext(pt_rdata[2*CW-1:CW]);
          state_r <= ST_PB;
        end
        ST_PB: begin
          bx_r    <= pt_rdata[CW-1:0];
          by_r    <= pt_rdata[2*CW-1:CW];
          dx_r    <= ext(pt_rdata[CW-1:0]) - ext(ax_r);
          dy_r    <= ext(pt_rdata[2*CW-1:CW]) - ext(ay_r);
          state_r <= ST_M_DXX;
        end
        ST_M_DXX: state_r <= ST_M_DYY;
        ST_M_DYY: begin
          len2_r  <= DEN_W'(p_r);
          state_r <= ST_M_WX;
        end
        ST_M_WX: begin
          len2_r  <= len2_r + DEN_W'(p_r);
          state_r <= ST_M_WY;
        end
        ST_M_WY: begin
          dot_r   <= DEN_W'(p_r);
          state_r <= ST_DOT;
        end
        ST_DOT: begin
          dot_r   <= dot_r + DEN_W'(p_r);
          state_r <= ST_CLAMP;
        end
        ST_CLAMP: begin
          // zero length or behind the start: start point; past the end: end point
          if (len2_r == '0 || dot_nonpos) begin
            px_r    <= ax_r;
            py_r    <= ay_r;
            state_r <= ST_ERR;
          end else if (dot_ge) begin
            px_r    <= bx_r;
            py_r    <= by_r;
            state_r <= ST_ERR;
          end else begin
            axis_r  <= 1'b0;
            state_r <= ST_P_LO;
          end
        end
        ST_P_LO: state_r <= ST_P_HI;
        ST_P_HI: begin
          nlo_r   <= DEN_W'(p_r);
          state_r <= ST_P_DIV;
        end
        ST_P_DIV: state_r <= ST_P_WAIT;
        ST_P_WAIT: begin
          if (it_sts.done) begin
            if (axis_r) begin
              py_r    <= proj[CW-1:0];
              state_r <= ST_ERR;
            end else begin
              px_r    <= proj[CW-1:0];
              axis_r  <= 1'b1;
              state_r <= ST_P_LO;
            end
          end
        end
        ST_ERR: begin
          ex_r    <= ext(px_r) - ext(qx_r);
          ey_r    <= ext(py_r) - ext(qy_r);
          state_r <= ST_E_XX;
        end
        ST_E_XX: state_r <= ST_E_YY;
        ST_E_YY: begin
          s_r     <= SQ_W'(p_r);
          state_r <= ST_E_SUM;
        end
        ST_E_SUM: state_r <= ST_SQ_WAIT;
        ST_SQ_WAIT: begin
          if (it_sts.done) begin
            // first strictly smaller distance wins
            if (!found_r || dist_sat < best_r) begin
              found_r   <= 1'b1;
              best_r    <= dist_sat;
              bx_best_r <= px_r;
              by_best_r <= py_r;
              bid_r     <= id_r;
            end
            seg_idx_r <= seg_idx_r + 1'b1;
            state_r   <= ST_SEG_RD;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_found_r  <= found_r;
            out_dist_r   <= best_r;
            out_px_r     <= bx_best_r;
            out_py_r     <= by_best_r;
            out_id_r     <= bid_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {3'b000, out_id_r, out_py_r, out_px_r, out_dist_r};

  // checks
  a_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !it_sts.busy)
    else $error("arithmetic unit busy while accepting beats");

  a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    it_sts.done |-> (state_r == ST_P_WAIT || state_r == ST_SQ_WAIT))
    else $error("arithmetic result outside a wait state");

  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[DW-1:0] == DIST_MAX && out_id_r == '0)
    else $error("not-found result carries data");

endmodule
